// ----- rtl/bm3_pkg.sv -----
// Shared types and constants of the 3x3 binary morphology block.
package bm3_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int MODE_BITS     = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_ZERO      = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FILL      = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FILL_ZERO = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_ZERO_FILL = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 11'd64;
    localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 11'd64;

    typedef enum logic [1:0] {
        OP_ZERO  = 2'd0,
        OP_FILL  = 2'd1,
        OP_IDENT = 2'd2
    } t_op;

    // Per-step token from a stage front to its back end.
    typedef struct packed {
        logic emit;    // this step emits a pixel
        logic first;   // emitted pixel is the first of its frame
        logic last;    // emitted pixel is the last of its frame
        logic top_in;  // row above is inside the frame
        logic bot_in;  // row below is inside the frame
        logic lft_in;  // column left is inside the frame
        logic rgt_in;  // column right is inside the frame
    } t_flags;

endpackage

// ----- rtl/bm3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bm3_queue.sv -----
// Short FIFO that decouples a stage front from its back end.
module bm3_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import bm3_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR   = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR-1:0]   r_wptr, r_rptr;
    logic [PTR:0]     r_count;
    logic             push_ok, pop_ok;

    assign o_ready = (r_count != (PTR+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) r_wptr <= r_wptr + 1'b1;
            if (pop_ok)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (PTR+1)'(push_ok) - (PTR+1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ----- rtl/bm3_front.sv -----
// Stage front: writes the line ring and decides which pixel each step emits.
module bm3_front #(
    parameter int CW = 11,
    parameter int RW = 11,
    parameter int PW = 11,
    parameter int AW = 12,
    parameter int PB = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic [CW-1:0]         i_width,
    input  logic [RW-1:0]         i_height,
    input  logic [CW+RW-1:0]      i_count,
    input  logic                  i_valid,
    input  logic                  i_has,
    input  logic [PB-1:0]         i_value,
    output logic                  o_ready,
    input  logic                  i_q_ready,
    output logic                  o_q_push,
    output bm3_pkg::t_flags       o_q_flags,
    output logic [AW-1:0]         o_q_addr,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [PB-1:0]         o_wdata
);
    import bm3_pkg::*;

    localparam int NW = CW + RW;

    logic [PW-1:0] r_pend, n_pend;
    logic [NW-1:0] r_outpos, n_outpos;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_emit_addr, n_emit_addr;
    logic [AW-1:0] r_wptr, n_wptr;

    logic          fire, emit;
    logic [PW-1:0] pend1;
    logic [NW-1:0] rem;
    t_flags        flags;

    assign o_ready = i_q_ready;
    assign fire    = i_valid && i_q_ready;
    assign pend1   = r_pend + PW'(i_has);
    assign rem     = i_count - r_outpos;
    assign emit    = fire && (pend1 != '0) &&
                     ((NW'(pend1) >= NW'(i_width) + NW'(2)) || (NW'(pend1) >= rem));

    always_comb begin
        flags.emit   = emit;
        flags.first  = (r_outpos == '0);
        flags.last   = (r_outpos == i_count - NW'(1));
        flags.top_in = (r_row != '0);
        flags.bot_in = ({1'b0, r_row} + (RW+1)'(1)) < {1'b0, i_height};
        flags.lft_in = (r_col != '0);
        flags.rgt_in = ({1'b0, r_col} + (CW+1)'(1)) < {1'b0, i_width};
    end

    always_comb begin
        n_pend      = r_pend;
        n_outpos    = r_outpos;
        n_row       = r_row;
        n_col       = r_col;
        n_emit_addr = r_emit_addr;
        n_wptr      = r_wptr;
        if (fire) begin
            n_pend = pend1;
            if (i_has) n_wptr = r_wptr + 1'b1;
        end
        if (emit) begin
            n_pend      = pend1 - PW'(1);
            n_emit_addr = r_emit_addr + 1'b1;
            // advance the raster position, wrap at frame end
            if (r_outpos + NW'(1) >= i_count) begin
                n_outpos = '0;
                n_row    = '0;
                n_col    = '0;
            end else begin
                n_outpos = r_outpos + NW'(1);
                if ({1'b0, r_col} + (CW+1)'(1) >= {1'b0, i_width}) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pend      <= '0;
            r_outpos    <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_emit_addr <= '0;
            r_wptr      <= '0;
        end else begin
            r_pend      <= n_pend;
            r_outpos    <= n_outpos;
            r_row       <= n_row;
            r_col       <= n_col;
            r_emit_addr <= n_emit_addr;
            r_wptr      <= n_wptr;
        end
    end

    assign o_q_push  = fire;
    assign o_q_flags = flags;
    assign o_q_addr  = r_emit_addr;
    assign o_we      = fire && i_has;
    assign o_waddr   = r_wptr;
    assign o_wdata   = i_value;
endmodule

// ----- rtl/bm3_back.sv -----
// Stage back end: reads window columns from the line ring and applies the operator.
module bm3_back #(
    parameter int CW = 11,
    parameter int AW = 12,
    parameter int PB = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_restart,
    input  bm3_pkg::t_op    i_op,
    input  logic [CW-1:0]   i_width,
    input  logic            i_valid,
    input  bm3_pkg::t_flags i_flags,
    input  logic [AW-1:0]   i_addr,
    output logic            o_pop,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  logic [PB-1:0]   i_wdata,
    output logic            o_valid,
    output bm3_pkg::t_flags o_flags,
    output logic [PB-1:0]   o_data,
    input  logic            i_ready
);
    import bm3_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic          adv, centre_now;
    logic [AW-1:0] base;
    logic [AW-1:0] raddr [3];
    logic [PB-1:0] rdata [3];

    logic          r_centre_done;
    logic          r_p1_valid, r_p1_centre;
    t_flags        r_p1_flags;
    logic          r_w_valid;
    t_flags        r_w_flags;
    logic [PB-1:0] r_win [3][3];
    logic          r_o_valid;
    t_flags        r_o_flags;
    logic [PB-1:0] r_o_data;
    logic [PB-1:0] result;

    assign adv        = !r_o_valid || i_ready;
    // the first pixel of a frame also needs its own column fetched
    assign centre_now = i_valid && i_flags.emit && i_flags.first && !r_centre_done;
    assign o_pop      = adv && i_valid && !centre_now;
    assign base       = centre_now ? i_addr : i_addr + AW'(1);
    assign raddr[0]   = base - AW'(i_width);
    assign raddr[1]   = base;
    assign raddr[2]   = base + AW'(i_width);

    for (genvar g = 0; g < 3; g++) begin : g_row
        bm3_ram #(.WIDTH(PB), .DEPTH(DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_we),
            .i_waddr (i_waddr),
            .i_wdata (i_wdata),
            .i_re    (adv),
            .i_raddr (raddr[g]),
            .o_rdata (rdata[g])
        );
    end

    always_comb begin
        logic any_zero, any_set, ok, interior;
        any_zero = 1'b0;
        any_set  = 1'b0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                ok = !(dr == 0 && !r_w_flags.top_in) && !(dr == 2 && !r_w_flags.bot_in) &&
                     !(dc == 0 && !r_w_flags.lft_in) && !(dc == 2 && !r_w_flags.rgt_in);
                if (ok && r_win[dr][dc] == '0) any_zero = 1'b1;
                if (ok && !(dr == 1 && dc == 1) && r_win[dr][dc] != '0) any_set = 1'b1;
            end
        end
        interior = r_w_flags.top_in && r_w_flags.bot_in &&
                   r_w_flags.lft_in && r_w_flags.rgt_in;
        case (i_op)
            OP_ZERO: result = any_zero ? '0 : r_win[1][1];
            OP_FILL: result = (interior && r_win[1][1] == '0 && any_set) ? PB'(1)
                                                                        : r_win[1][1];
            default: result = r_win[1][1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_centre_done <= 1'b0;
            r_p1_valid    <= 1'b0;
            r_p1_centre   <= 1'b0;
            r_w_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
        end else if (adv) begin
            if (i_valid) r_centre_done <= centre_now;
            r_p1_valid  <= i_valid;
            r_p1_centre <= centre_now;
            r_w_valid   <= r_p1_valid && !r_p1_centre;
            r_o_valid   <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_flags <= i_flags;
            r_w_flags  <= r_p1_flags;
            r_o_flags  <= r_w_flags;
            r_o_data   <= result;
            // shift in the fetched column
            if (r_p1_valid && r_p1_flags.emit) begin
                for (int dr = 0; dr < 3; dr++) begin
                    r_win[dr][0] <= r_win[dr][1];
                    r_win[dr][1] <= r_win[dr][2];
                    r_win[dr][2] <= rdata[dr];
                end
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_flags = r_o_flags;
    assign o_data  = r_o_data;
endmodule

// ----- rtl/binary_morphology_3x3_core.sv -----
// Top level of the streaming 3x3 binary morphology block.
//
// Pixels of a frame_width x frame_height frame enter one per beat in raster
// order (cmd 0), or a flush beat (cmd 1) drains the tail of a finished frame.
// Two cascaded 3x3 stages run the selected mode: zero-spread, fill, fill then
// zero-spread, or zero-spread then fill. Each stage has a front that writes a
// ring of line stores and decides which pixel the beat releases, a four-entry
// queue, and a back end that fetches one window column a cycle, unless its
// output stalls, from three copies of the ring and applies the operator.
// Sustained rate is one beat per cycle while the output is not stalled. The
// first pixel of every frame needs an extra fetch of its own column in each
// back end; the queues absorb it unless frames of only a few pixels follow
// each other back to back. A stage releases a pixel on the beat that brings
// in the pixel one row and one column beyond it, or on the beats after its
// frame is complete, and its result then passes the back end's fetch, window
// and output registers before it leaves. Line stores need no clearing pass.
// Any register write restarts the pipeline and drops pixels in flight; input
// ready drops for one cycle after a write while the frame size settles.
module binary_morphology_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic [7:0]                           i_pixel_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [7:0]                           o_pixel_out,
    output logic                                 o_frame_last,
    input  logic                                 i_cfg_we,
    input  logic [bm3_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [bm3_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import bm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int NW = CW + RW;
    localparam int PW = $clog2(MAX_WIDTH + 3);
    localparam int AW = $clog2(MAX_WIDTH) + 2;
    localparam int PB = PIXEL_BITS;
    localparam int FW = $bits(t_flags);
    localparam int QW = FW + AW;

    // Configuration registers
    logic [MODE_BITS-1:0]     r_mode;
    logic [CFG_DATA_BITS-1:0] r_width, r_height;
    logic [NW-1:0]            r_count;
    logic                     r_hold;
    logic                     restart;
    logic [CW-1:0]            eff_w;
    logic [RW-1:0]            eff_h;
    t_op                      op1, op2;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx) inside
                CFG_MODE, CFG_WIDTH, CFG_HEIGHT: restart = 1'b1;
                default:                         restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ZERO;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_hold   <= 1'b0;
        end else begin
            r_hold <= restart;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   r_mode   <= i_cfg_data[MODE_BITS-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Clamp out-of-range sizes: zero acts as one, above the maximum as the maximum
    always_comb begin
        if (r_width == '0)                   eff_w = CW'(1);
        else if (int'(r_width) > MAX_WIDTH)  eff_w = CW'(MAX_WIDTH);
        else                                 eff_w = CW'(r_width);
        if (r_height == '0)                  eff_h = RW'(1);
        else if (int'(r_height) > MAX_HEIGHT) eff_h = RW'(MAX_HEIGHT);
        else                                 eff_h = RW'(r_height);
    end

    always_ff @(posedge i_clk) begin
        r_count <= NW'(eff_w) * NW'(eff_h);
    end

    always_comb begin
        case (r_mode)
            MODE_FILL:      begin op1 = OP_FILL; op2 = OP_IDENT; end
            MODE_FILL_ZERO: begin op1 = OP_FILL; op2 = OP_ZERO;  end
            MODE_ZERO_FILL: begin op1 = OP_ZERO; op2 = OP_FILL;  end
            default:        begin op1 = OP_ZERO; op2 = OP_IDENT; end
        endcase
    end

    // Stage one
    logic          s1_ready, s1_push, s1_we, s1q_ready, s1q_valid, s1_pop;
    t_flags        s1_flags;
    logic [AW-1:0] s1_addr, s1_waddr;
    logic [PB-1:0] s1_wdata;
    logic [QW-1:0] s1q_data;
    logic          b1_valid, b1_ready;
    t_flags        b1_flags;
    logic [PB-1:0] b1_data;

    assign o_ready = s1_ready && !r_hold;

    bm3_front #(.CW(CW), .RW(RW), .PW(PW), .AW(AW), .PB(PB)) u_front1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .i_count   (r_count),
        .i_valid   (i_valid && !r_hold),
        .i_has     (!i_cmd),
        .i_value   (PB'(i_pixel_in)),
        .o_ready   (s1_ready),
        .i_q_ready (s1q_ready),
        .o_q_push  (s1_push),
        .o_q_flags (s1_flags),
        .o_q_addr  (s1_addr),
        .o_we      (s1_we),
        .o_waddr   (s1_waddr),
        .o_wdata   (s1_wdata)
    );

    bm3_queue #(.WIDTH(QW)) u_queue1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_push    (s1_push),
        .i_data    ({s1_flags, s1_addr}),
        .o_ready   (s1q_ready),
        .o_valid   (s1q_valid),
        .o_data    (s1q_data),
        .i_pop     (s1_pop)
    );

    bm3_back #(.CW(CW), .AW(AW), .PB(PB)) u_back1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_op      (op1),
        .i_width   (eff_w),
        .i_valid   (s1q_valid),
        .i_flags   (t_flags'(s1q_data[QW-1:AW])),
        .i_addr    (s1q_data[AW-1:0]),
        .o_pop     (s1_pop),
        .i_we      (s1_we),
        .i_waddr   (s1_waddr),
        .i_wdata   (s1_wdata),
        .o_valid   (b1_valid),
        .o_flags   (b1_flags),
        .o_data    (b1_data),
        .i_ready   (b1_ready)
    );

    // Stage two steps once per beat of stage one, emitted or not
    logic          s2_push, s2_we, s2q_ready, s2q_valid, s2_pop;
    t_flags        s2_flags;
    logic [AW-1:0] s2_addr, s2_waddr;
    logic [PB-1:0] s2_wdata;
    logic [QW-1:0] s2q_data;
    logic          b2_valid, b2_ready;
    t_flags        b2_flags;
    logic [PB-1:0] b2_data;

    bm3_front #(.CW(CW), .RW(RW), .PW(PW), .AW(AW), .PB(PB)) u_front2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .i_count   (r_count),
        .i_valid   (b1_valid),
        .i_has     (b1_flags.emit),
        .i_value   (b1_data),
        .o_ready   (b1_ready),
        .i_q_ready (s2q_ready),
        .o_q_push  (s2_push),
        .o_q_flags (s2_flags),
        .o_q_addr  (s2_addr),
        .o_we      (s2_we),
        .o_waddr   (s2_waddr),
        .o_wdata   (s2_wdata)
    );

    bm3_queue #(.WIDTH(QW)) u_queue2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_push    (s2_push),
        .i_data    ({s2_flags, s2_addr}),
        .o_ready   (s2q_ready),
        .o_valid   (s2q_valid),
        .o_data    (s2q_data),
        .i_pop     (s2_pop)
    );

    bm3_back #(.CW(CW), .AW(AW), .PB(PB)) u_back2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_op      (op2),
        .i_width   (eff_w),
        .i_valid   (s2q_valid),
        .i_flags   (t_flags'(s2q_data[QW-1:AW])),
        .i_addr    (s2q_data[AW-1:0]),
        .o_pop     (s2_pop),
        .i_we      (s2_we),
        .i_waddr   (s2_waddr),
        .i_wdata   (s2_wdata),
        .o_valid   (b2_valid),
        .o_flags   (b2_flags),
        .o_data    (b2_data),
        .i_ready   (b2_ready)
    );

    // Drop beats that carry no pixel; present the rest
    assign o_valid      = b2_valid && b2_flags.emit;
    assign b2_ready     = i_ready || !b2_flags.emit;
    assign o_pixel_out  = 8'(b2_data);
    assign o_frame_last = b2_flags.last;
endmodule

// ----- rtl/bm3_checker.sv -----
// Port-level checks of the 3x3 morphology block and their bind.
module bm3_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [7:0]                        o_pixel_out,
    input logic                              o_frame_last,
    input logic                              i_cfg_we,
    input logic [bm3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx
);
    import bm3_pkg::*;

    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_MODE || i_cfg_idx == CFG_WIDTH ||
                                  i_cfg_idx == CFG_HEIGHT);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out) && $stable(o_frame_last))
        else $error("stalled output beat changed");

    // A register write drops results in flight
    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> !o_valid)
        else $error("output valid after restart");

    // Input is not ready in the cycle after a register write
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> !o_ready)
        else $error("input accepted while size settles");
endmodule

bind binary_morphology_3x3_core bm3_checker u_bm3_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the streaming 3x3 binary morphology core.
module tb_top;
    import bm3_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int RING_DEPTH = 2 * LINE_MAX + 3;
    localparam int RAND_ITEMS = 740;
    localparam int HOLD_CYCLES = 4000;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic {ITEM_BEAT, ITEM_CFG} t_kind;

    typedef struct {
        t_kind                     kind;
        logic                      cmd;
        logic [7:0]                pixel;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_item;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } t_out_pixel;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_cmd;
    logic [7:0]                i_pixel_in;
    logic                      o_valid;
    logic                      i_ready;
    logic [7:0]                o_pixel_out;
    logic                      o_frame_last;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    binary_morphology_3x3_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock: 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor state: configuration, two line rings and per-stage control.
    // Index 0 is the first stage, index 1 the second.
    // ------------------------------------------------------------------
    logic [MODE_BITS-1:0]     cur_mode;
    logic [CFG_DATA_BITS-1:0] cur_width;
    logic [CFG_DATA_BITS-1:0] cur_height;

    logic [7:0] line_ring [2][RING_DEPTH];
    int         ring_wr   [2];
    int         ring_base [2];
    int         held_cnt  [2];
    int         out_row   [2];
    int         out_col   [2];
    int         out_idx   [2];

    t_out_pixel pending_pixels [$];
    t_item      item_q [$];

    int accepted_cnt = 0;
    int issued_cnt   = 0;
    int err_cnt      = 0;

    function automatic int frame_w();
        if (cur_width == 0) return 1;
        if (cur_width > LINE_MAX) return LINE_MAX;
        return cur_width;
    endfunction

    function automatic int frame_h();
        if (cur_height == 0) return 1;
        if (cur_height > LINE_MAX) return LINE_MAX;
        return cur_height;
    endfunction

    // Return both stages to the start of a frame; ring contents stay.
    function automatic void restart_stages();
        for (int s = 0; s < 2; s++) begin
            ring_wr[s]   = 0;
            ring_base[s] = 0;
            held_cnt[s]  = 0;
            out_row[s]   = 0;
            out_col[s]   = 0;
            out_idx[s]   = 0;
        end
    endfunction

    // One beat through one stage: store the incoming pixel, then release the
    // pixel at the output position once its lower-right neighbor is in, or
    // once the rest of the frame is in.
    function automatic bit stage_step(input int s, input t_op op, input bit has,
                                      input logic [7:0] v, output logic [7:0] res,
                                      output logic last);
        int w, h, n, rem, r, c, ctr, dr, dc;
        bit ok, any_zero, any_set, interior;
        logic [7:0] px, centre_px;
        w = frame_w();
        h = frame_h();
        n = w * h;
        res = '0;
        last = 1'b0;
        any_zero = 0;
        any_set = 0;
        centre_px = '0;
        if (has) begin
            line_ring[s][ring_wr[s]] = v;
            ring_wr[s] = (ring_wr[s] + 1) % RING_DEPTH;
            held_cnt[s]++;
        end
        rem = n - out_idx[s];
        if (held_cnt[s] == 0 || (held_cnt[s] < w + 2 && held_cnt[s] < rem)) return 0;

        r = out_row[s];
        c = out_col[s];
        ctr = (ring_base[s] + out_idx[s]) % RING_DEPTH;
        for (int k = 0; k < 9; k++) begin
            dr = k / 3;
            dc = k % 3;
            ok = !(dr == 0 && r == 0) && !(dr == 2 && r + 1 >= h) &&
                 !(dc == 0 && c == 0) && !(dc == 2 && c + 1 >= w);
            if (ok) begin
                px = line_ring[s][(ctr + RING_DEPTH - w - 1 + dr * w + dc) % RING_DEPTH];
                if (px == 0) any_zero = 1;
                if (k != 4 && px != 0) any_set = 1;
                if (k == 4) centre_px = px;
            end
        end

        case (op)
            OP_ZERO: res = any_zero ? 8'd0 : centre_px;
            OP_FILL: begin
                interior = r >= 1 && r + 1 < h && c >= 1 && c + 1 < w;
                res = (interior && centre_px == 0 && any_set) ? 8'd1 : centre_px;
            end
            default: res = centre_px;
        endcase
        last = (out_idx[s] == n - 1);

        held_cnt[s]--;
        out_col[s]++;
        if (out_col[s] >= w) begin
            out_col[s] = 0;
            out_row[s]++;
        end
        out_idx[s]++;
        if (out_idx[s] >= n) begin
            out_idx[s]   = 0;
            out_row[s]   = 0;
            out_col[s]   = 0;
            ring_base[s] = (ring_base[s] + n) % RING_DEPTH;
        end
        return 1;
    endfunction

    // Run one accepted beat through both stages; queue the result if any.
    function automatic void morph_step(input logic cmd, input logic [7:0] pix);
        t_op op1, op2;
        logic [7:0] mid, res;
        logic l1, l2;
        bit got;
        t_out_pixel e;
        op1 = (cur_mode == MODE_FILL || cur_mode == MODE_FILL_ZERO) ? OP_FILL : OP_ZERO;
        op2 = (cur_mode == MODE_FILL_ZERO) ? OP_ZERO :
              (cur_mode == MODE_ZERO_FILL) ? OP_FILL : OP_IDENT;
        got = stage_step(0, op1, cmd == CMD_PIXEL, pix, mid, l1);
        if (stage_step(1, op2, got, mid, res, l2)) begin
            e.pixel = res;
            e.last  = l2;
            pending_pixels.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    int rand_items = 0;

    function automatic void push_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0] data);
        t_item it;
        it.kind  = ITEM_CFG;
        it.cmd   = CMD_FLUSH;
        it.pixel = '0;
        it.idx   = idx;
        it.data  = data;
        item_q.push_back(it);
    endfunction

    function automatic void push_beat(input logic cmd, input logic [7:0] pix);
        t_item it;
        it.kind  = ITEM_BEAT;
        it.cmd   = cmd;
        it.pixel = pix;
        it.idx   = CFG_MODE;
        it.data  = '0;
        item_q.push_back(it);
        rand_items++;
    endfunction

    function automatic logic [7:0] rand_pixel(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return 8'd0;
        case ($urandom_range(0, 3))
            0: return 8'd255;
            1: return 8'd1;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Push a whole frame, sometimes with a flush beat dropped inside it
    // (it must be ignored since the frame is incomplete).
    function automatic void push_frame(input int w, input int h, input int zero_pct);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 15) == 0) push_beat(CMD_FLUSH, 8'($urandom));
            push_beat(CMD_PIXEL, rand_pixel(zero_pct));
        end
    endfunction

    function automatic void push_flushes(input int cnt);
        for (int i = 0; i < cnt; i++) push_beat(CMD_FLUSH, 8'($urandom));
    endfunction

    function automatic void push_setup(input logic [MODE_BITS-1:0] m,
                                       input int w, input int h);
        push_cfg(CFG_MODE, CFG_DATA_BITS'(m));
        push_cfg(CFG_WIDTH, CFG_DATA_BITS'(w));
        push_cfg(CFG_HEIGHT, CFG_DATA_BITS'(h));
    endfunction

    function automatic int clamp_size(input int v);
        if (v == 0) return 1;
        if (v > LINE_MAX) return LINE_MAX;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: track config writes and accepted beats, check every result
    // beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result beat: pixel_out %0d frame_last %0d",
                           o_pixel_out, o_frame_last);
                    err_cnt++;
                end else begin
                    if (o_pixel_out !== pending_pixels[0].pixel) begin
                        $error("pixel_out: expected %0d, got %0d",
                               pending_pixels[0].pixel, o_pixel_out);
                        err_cnt++;
                    end
                    if (o_frame_last !== pending_pixels[0].last) begin
                        $error("frame_last: expected %0d, got %0d",
                               pending_pixels[0].last, o_frame_last);
                        err_cnt++;
                    end
                    void'(pending_pixels.pop_front());
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   cur_mode   = i_cfg_data[MODE_BITS-1:0];
                    CFG_WIDTH:  cur_width  = i_cfg_data;
                    CFG_HEIGHT: cur_height = i_cfg_data;
                    default: ;
                endcase
                restart_stages();
            end
            if (i_valid && o_ready) begin
                accepted_cnt++;
                morph_step(i_cmd, i_pixel_in);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps; config writes only once the
    // block has drained and the latency tail has passed.
    // ------------------------------------------------------------------
    int burst_left  = 8;
    int gap_left    = 0;
    int settle_cnt  = 0;
    int accepted_at_cfg = 0;

    always @(negedge i_clk) begin : driver
        logic  v_n;
        logic  we_n;
        t_item it;
        v_n  = i_valid;
        we_n = 1'b0;
        if (!i_rst_n) begin
            v_n = 1'b0;
        end else begin
            // Drop valid once the beat went through.
            if (i_valid && accepted_cnt == issued_cnt) v_n = 1'b0;
            if (v_n || pending_pixels.size() != 0) settle_cnt = 0;
            else settle_cnt++;
            if (!v_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_q.size() > 0) begin
                    if (item_q[0].kind == ITEM_CFG) begin
                        if (pending_pixels.size() == 0 &&
                            (accepted_cnt == accepted_at_cfg ||
                             settle_cnt >= 2 * frame_w() + 64)) begin
                            it = item_q.pop_front();
                            we_n = 1'b1;
                            i_cfg_idx  <= it.idx;
                            i_cfg_data <= it.data;
                            accepted_at_cfg = accepted_cnt;
                        end
                    end else begin
                        it = item_q.pop_front();
                        v_n = 1'b1;
                        i_cmd      <= it.cmd;
                        i_pixel_in <= it.pixel;
                        issued_cnt++;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                end
            end
        end
        i_valid  <= v_n;
        i_cfg_we <= we_n;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern picked from four settings by bits 11:10 of rx_cycle,
    // plus one long hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    int  rx_cycle  = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && accepted_cnt >= 150) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            case ((rx_cycle >> 10) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 7) != 0);
                2: i_ready <= ($urandom_range(0, 1) != 0);
                default: i_ready <= ($urandom_range(0, 7) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int w, h, m, frames;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_PIXEL;
        i_pixel_in = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MODE;
        i_cfg_data = '0;
        cur_mode   = MODE_ZERO;
        cur_width  = RESET_WIDTH;
        cur_height = RESET_HEIGHT;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < RING_DEPTH; i++) line_ring[s][i] = '0;
        restart_stages();

        // Directed: zero-spread with a zero corner, fill of a hole,
        // a small frame where fill must change nothing.
        push_setup(MODE_ZERO, 3, 3);
        push_beat(CMD_FLUSH, 8'd0);
        push_beat(CMD_PIXEL, 8'd0);
        for (int i = 0; i < 8; i++) push_beat(CMD_PIXEL, 8'd255);
        push_flushes(12);
        push_setup(MODE_FILL, 3, 3);
        for (int i = 0; i < 9; i++) push_beat(CMD_PIXEL, (i == 4) ? 8'd0 : 8'd170);
        push_beat(CMD_PIXEL, 8'd85);
        push_beat(CMD_PIXEL, 8'd0);
        push_flushes(12);
        push_setup(MODE_FILL, 2, 2);
        push_beat(CMD_PIXEL, 8'd0);
        push_beat(CMD_PIXEL, 8'd255);
        push_beat(CMD_PIXEL, 8'd255);
        push_beat(CMD_PIXEL, 8'd0);
        push_flushes(8);

        // One column wide, height clamped to the maximum, cut short by the
        // next register write; the long hold-off lands here.
        push_setup(MODE_ZERO_FILL, 0, 2047);
        push_frame(1, 200, 25);
        // Start a huge frame with clamped width and abandon it.
        push_setup(MODE_ZERO, 2047, 1025);
        push_frame(1, 40, 30);

        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            m = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 1;
                2: w = 2;
                3: w = 3;
                default: w = $urandom_range(4, 12);
            endcase
            case ($urandom_range(0, 7))
                0: h = 0;
                1: h = 1;
                2: h = 2;
                default: h = $urandom_range(3, 8);
            endcase
            push_setup(MODE_BITS'(m), w, h);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                push_frame(clamp_size(w), clamp_size(h), $urandom_range(5, 50));
                // Zero flushes here makes frames follow back to back.
                if ($urandom_range(0, 1) == 0) push_flushes($urandom_range(0, w + 3));
            end
            push_flushes(2 * clamp_size(w) + 6);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || i_valid || i_cfg_we) @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * frame_w() + 64) @(posedge i_clk);
        if (err_cnt == 0 && pending_pixels.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
